// ===== hw/rtl/lpsbe_pkg.sv =====
// Shared constants and channel scale/encode functions for the LED pixel SPI encoder.
`default_nettype none

package lpsbe_pkg;

    localparam int unsigned CHAN_W          = 8;
    localparam int unsigned PIXEL_W         = 3 * CHAN_W;
    localparam int unsigned ENC_CHAN_W      = 3 * CHAN_W;
    localparam int unsigned ENC_PIXEL_W     = 3 * ENC_CHAN_W;
    localparam int unsigned PIXEL_BYTES     = 9;
    localparam int unsigned RESET_BYTES_DEF = 24;

    localparam logic [CHAN_W-1:0] BRIGHT_FULL = 8'hFF;

    // Three-bit line codes for one data bit.
    localparam logic [2:0] ENC_ONE  = 3'b110;
    localparam logic [2:0] ENC_ZERO = 3'b100;

    typedef logic [CHAN_W-1:0]      chan_t;
    typedef logic [ENC_CHAN_W-1:0]  enc_chan_t;
    typedef logic [ENC_PIXEL_W-1:0] enc_pixel_t;

    // floor(v * b / 255) via (p + 1 + (p >> 8)) >> 8, exact for p <= 65534.
    function automatic chan_t scale_channel(input chan_t v, input chan_t b);
        logic [15:0] prod;
        logic [16:0] sum;
        prod = 16'(v) * 16'(b);
        sum  = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
        return sum[15:8];
    endfunction

    // MSB of the channel lands in the top three bits.
    function automatic enc_chan_t encode_channel(input chan_t v);
        enc_chan_t code;
        for (int i = 0; i < CHAN_W; i++) begin
            code[3*i +: 3] = v[i] ? ENC_ONE : ENC_ZERO;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lpsbe_pixel_enc.sv =====
// Scales one pixel by brightness and encodes it into nine SPI bytes (G, R, B order).
`default_nettype none

module lpsbe_pixel_enc
    import lpsbe_pkg::*;
(
    input  wire chan_t      red,
    input  wire chan_t      green,
    input  wire chan_t      blue,
    input  wire chan_t      brightness,
    output enc_pixel_t      enc_pixel
);

    chan_t red_s;
    chan_t green_s;
    chan_t blue_s;

    assign red_s   = scale_channel(red, brightness);
    assign green_s = scale_channel(green, brightness);
    assign blue_s  = scale_channel(blue, brightness);

    // Green goes out first, so it sits in the top bytes.
    assign enc_pixel = {encode_channel(green_s), encode_channel(red_s), encode_channel(blue_s)};

endmodule

`default_nettype wire

// ===== hw/rtl/led_pixel_spi_bit_encoder.sv =====
// Top level of the LED pixel SPI bit encoder: pixel register, encoder and byte shifter.
`default_nettype none

// Takes one pixel per input beat (red, green, blue, tlast = last pixel of the
// frame), scales each channel by brightness as floor(value*brightness/255) and
// emits nine SPI bytes per pixel in green, red, blue order, each data bit coded
// MSB first as 110 (one) or 100 (zero). A pixel with tlast set is followed by
// RESET_BYTES zero bytes for the latch gap. m_tlast marks the final byte that a
// pixel produces. Output runs at one byte per cycle while m_tready is high; the
// single output byte shifter sends the nine bytes, plus RESET_BYTES after the
// last pixel of a frame. A pixel register in front of the shifter takes the
// next pixel while the current one is still going out, so with m_tready held
// high bytes leave with no gaps; each pixel goes from that register into the
// shifter. brightness resets to 255 (full scale) and is written through
// brightness_we / brightness_wdata; write it only while the block is idle.

module led_pixel_spi_bit_encoder
    import lpsbe_pkg::*;
#(
    parameter int unsigned RESET_BYTES = RESET_BYTES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,

    // brightness register write
    input  wire         brightness_we,
    input  wire  [7:0]  brightness_wdata,

    // pixel input
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [23:0] s_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    input  wire         s_tlast,    // last pixel of the frame

    // SPI byte output
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [7:0]  m_tdata,    // [7:0] spi byte
    output logic        m_tlast     // final byte for this pixel
);

    localparam int unsigned TOTAL_MAX = PIXEL_BYTES + RESET_BYTES;
    localparam int unsigned CNT_W     = $clog2(TOTAL_MAX);

    localparam logic [CNT_W-1:0] LAST_PLAIN = CNT_W'(PIXEL_BYTES - 1);
    localparam logic [CNT_W-1:0] LAST_FRAME = CNT_W'(TOTAL_MAX - 1);

    // Config
    chan_t brightness_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= BRIGHT_FULL;
        end else if (brightness_we) begin
            brightness_reg <= brightness_wdata;
        end
    end

    // Pixel holding register
    logic                pix_valid_reg;
    logic                pix_valid_next;
    logic [PIXEL_W-1:0]  pix_data_reg;
    logic                pix_last_reg;

    // Output shifter
    logic                out_valid_reg;
    logic                out_valid_next;
    enc_pixel_t          shift_reg;
    enc_pixel_t          shift_next;
    logic [CNT_W-1:0]    remain_reg;
    logic [CNT_W-1:0]    remain_next;

    logic       in_beat;
    logic       out_beat;
    logic       out_done;
    logic       shifter_free;
    logic       load;
    enc_pixel_t enc_pixel;

    assign in_beat      = s_tvalid && s_tready;
    assign out_beat     = out_valid_reg && m_tready;
    assign out_done     = out_beat && (remain_reg == '0);
    assign shifter_free = !out_valid_reg || out_done;
    assign load         = pix_valid_reg && shifter_free;

    assign s_tready = !pix_valid_reg || shifter_free;

    lpsbe_pixel_enc u_enc (
        .red        (pix_data_reg[7:0]),
        .green      (pix_data_reg[15:8]),
        .blue       (pix_data_reg[23:16]),
        .brightness (brightness_reg),
        .enc_pixel  (enc_pixel)
    );

    always_comb begin
        pix_valid_next = pix_valid_reg;
        if (in_beat) begin
            pix_valid_next = 1'b1;
        end else if (load) begin
            pix_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_valid_reg <= 1'b0;
        end else begin
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_beat) begin
            pix_data_reg <= s_tdata;
            pix_last_reg <= s_tlast;
        end
    end

    // Shift in zeros: once the nine pixel bytes are out, the reset gap
    // bytes come out as zero with no extra muxing.
    always_comb begin
        out_valid_next = out_valid_reg;
        shift_next     = shift_reg;
        remain_next    = remain_reg;
        if (load) begin
            out_valid_next = 1'b1;
            shift_next     = enc_pixel;
            remain_next    = pix_last_reg ? LAST_FRAME : LAST_PLAIN;
        end else if (out_done) begin
            out_valid_next = 1'b0;
        end else if (out_beat) begin
            shift_next  = {shift_reg[ENC_PIXEL_W-9:0], 8'h00};
            remain_next = remain_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            remain_reg    <= '0;
        end else begin
            out_valid_reg <= out_valid_next;
            remain_reg    <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = shift_reg[ENC_PIXEL_W-1 -: 8];
    assign m_tlast  = (remain_reg == '0);

endmodule

`default_nettype wire

// ===== tb/sv/lpsbe_spi_checker.sv =====
// Checker for the LED pixel SPI encoder: predicts the SPI byte stream and compares each output beat.
module lpsbe_spi_checker
    import lpsbe_pkg::*;
#(
    parameter int unsigned RESET_GAP = RESET_BYTES_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         brightness_we,
    input  wire  [7:0]  brightness_wdata,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [23:0] s_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    input  wire         s_tlast,    // last pixel of the frame
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [7:0]  m_tdata,    // [7:0] spi byte
    input  wire         m_tlast,    // final byte for this pixel
    output int          err_count,
    output int          bytes_pending,
    output int          bytes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       final_byte;
    } spi_beat_t;

    spi_beat_t spi_byte_q[$];
    chan_t     bright = BRIGHT_FULL;
    int        shown  = 0;

    // floor(v * b / 255) in plain integer math
    function automatic chan_t dim_channel(input chan_t v, input chan_t b);
        int unsigned prod;
        prod = v;
        prod = prod * b;
        return chan_t'(prod / 255);
    endfunction

    // MSB first, three line bits per data bit
    function automatic logic [23:0] line_code(input chan_t v);
        logic [23:0] code;
        code = '0;
        for (int bit_i = 7; bit_i >= 0; bit_i--) begin
            code = {code[20:0], (v[bit_i] ? ENC_ONE : ENC_ZERO)};
        end
        return code;
    endfunction

    function automatic void queue_pixel(input chan_t red, input chan_t green,
                                        input chan_t blue, input logic last);
        chan_t       chans [3];
        logic [23:0] code;
        chans[0] = dim_channel(green, bright);
        chans[1] = dim_channel(red, bright);
        chans[2] = dim_channel(blue, bright);
        for (int c = 0; c < 3; c++) begin
            code = line_code(chans[c]);
            spi_byte_q.push_back('{code[23:16], 1'b0});
            spi_byte_q.push_back('{code[15:8], 1'b0});
            spi_byte_q.push_back('{code[7:0], 1'b0});
        end
        if (last) begin
            repeat (RESET_GAP) spi_byte_q.push_back('{8'h00, 1'b0});
        end
        spi_byte_q[spi_byte_q.size() - 1].final_byte = 1'b1;
    endfunction

    always @(posedge aclk) begin : watch
        spi_beat_t got;
        spi_beat_t want;
        if (!aresetn) begin
            bright = BRIGHT_FULL;
            spi_byte_q.delete();
        end else begin
            // outputs first: a pixel taken at this edge cannot produce a byte yet
            if (m_tvalid && m_tready) begin
                got = '{m_tdata, m_tlast};
                bytes_checked++;
                if (spi_byte_q.size() == 0) begin
                    err_count++;
                    if (shown < 10) begin
                        $display("%0t: unexpected byte: data %02h final %0b",
                                 $realtime, got.spi_byte, got.final_byte);
                    end
                    shown++;
                end else begin
                    want = spi_byte_q.pop_front();
                    if (got !== want) begin
                        err_count++;
                        if (shown < 10) begin
                            $display({"%0t: byte mismatch: expected data %02h final %0b,",
                                      " got data %02h final %0b"}, $realtime,
                                     want.spi_byte, want.final_byte,
                                     got.spi_byte, got.final_byte);
                        end
                        shown++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                queue_pixel(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tlast);
            end
            if (brightness_we) begin
                bright = brightness_wdata;
            end
        end
        bytes_pending = spi_byte_q.size();
    end

endmodule

// ===== tb/sv/led_pixel_spi_bit_encoder_tb.sv =====
// Testbench top for the LED pixel SPI encoder: clock, reset, pixel stimulus and verdict.
module led_pixel_spi_bit_encoder_tb
    import lpsbe_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS   = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 16;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_PIXELS  = 60;         // 8 x 60 = 480 random pixels
    localparam int RUN_LIMIT_NS  = 5_000_000;  // watchdog limit, far beyond worst stall

    // receiver stall patterns
    typedef enum int {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        brightness_we    = 1'b0;
    logic [7:0]  brightness_wdata = 8'h00;
    logic        s_tvalid         = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata          = '0;   // [7:0] red, [15:8] green, [23:16] blue
    logic        s_tlast          = 1'b0; // last pixel of the frame
    logic        m_tvalid;
    logic        m_tready         = 1'b0;
    logic [7:0]  m_tdata;                 // [7:0] spi byte
    logic        m_tlast;                 // final byte for this pixel

    int err_count;
    int bytes_pending;
    int bytes_checked;

    int       burst_left     = 0;
    int       pixels_sent    = 0;
    int       frames_sent    = 0;
    int       settings_used  = 1;  // reset value counts as the first
    rx_mode_t rx_mode        = RX_STEADY;
    int       rx_left        = 0;

    always #(CLK_HALF_NS) aclk = ~aclk;

    led_pixel_spi_bit_encoder #(
        .RESET_BYTES (RESET_BYTES_DEF)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .brightness_we    (brightness_we),
        .brightness_wdata (brightness_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast)
    );

    // Watches both channels and the brightness write, keeps the expected byte stream.
    lpsbe_spi_checker #(
        .RESET_GAP (RESET_BYTES_DEF)
    ) spi_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .brightness_we    (brightness_we),
        .brightness_wdata (brightness_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .err_count        (err_count),
        .bytes_pending    (bytes_pending),
        .bytes_checked    (bytes_checked)
    );

    // Receiver: holds one stall pattern for a random stretch, then picks another.
    // The steady pattern gives long runs with no back-pressure at all.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end
        rx_left--;
        case (rx_mode)
            RX_STEADY:   m_tready = 1'b1;
            RX_LIGHT:    m_tready = ($urandom_range(0, 3) != 0);
            RX_HEAVY:    m_tready = ($urandom_range(0, 3) == 0);
            RX_PERIODIC: m_tready = ((rx_left % 7) > 2);
            default:     m_tready = 1'b1;
        endcase
    end

    // One pixel beat. Beats go out in bursts; a burst starts after a random gap,
    // sometimes none, so gaps land on every byte slot of the pixel in flight.
    task automatic send_pixel(input chan_t red, input chan_t green, input chan_t blue,
                              input logic last);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_tdata  = {blue, green, red};
        s_tlast  = last;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        pixels_sent++;
        if (last) frames_sent++;
    endtask

    // Brightness may only change with the block drained: wait out every byte,
    // then let the block settle, then a single write cycle.
    task automatic set_brightness(input chan_t level);
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (bytes_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        brightness_we    = 1'b1;
        brightness_wdata = level;
        @(negedge aclk);
        brightness_we    = 1'b0;
        settings_used++;
    endtask

    // channel value with extra weight on the two ends of the range
    function automatic chan_t pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // full scale straight out of reset: values pass through unchanged
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);  // channel order check
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'hFF, 1'b0);
        send_pixel(8'h55, 8'hAA, 8'h81, 1'b0);
        send_pixel(8'h01, 8'h80, 8'h7F, 1'b1);  // frame end: reset run follows
        send_pixel(8'h12, 8'h34, 8'h56, 1'b1);  // single-pixel frame right after

        // zero brightness: everything encodes as all-zero bits
        set_brightness(8'h00);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
        send_pixel(8'h80, 8'h01, 8'hAA, 1'b1);

        // smallest nonzero: only 255 survives the floor
        set_brightness(8'h01);
        send_pixel(8'hFF, 8'hFE, 8'h01, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);

        set_brightness(8'h80);
        send_pixel(8'hFF, 8'h80, 8'h7F, 1'b0);
        send_pixel(8'h03, 8'hFD, 8'h40, 1'b1);

        set_brightness(8'hFE);
        send_pixel(8'hFF, 8'hFE, 8'h80, 1'b0);

        set_brightness(8'hFF);
        send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);

        // random frames, one brightness per phase; about one pixel in eight ends a frame
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0:       set_brightness(8'hFF);
                1:       set_brightness(8'h00);
                2:       set_brightness(chan_t'($urandom_range(2, 253)));
                3:       set_brightness(8'h01);
                4:       set_brightness(8'hFE);
                5:       set_brightness(8'h80);
                6:       set_brightness(chan_t'($urandom_range(0, 255)));
                default: set_brightness(8'hFF);
            endcase
            repeat (PHASE_PIXELS) begin
                send_pixel(pick_level(), pick_level(), pick_level(),
                           ($urandom_range(0, 7) == 0));
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (bytes_pending != 0) @(negedge aclk);
        // catch any stray bytes after the stream should have ended
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("summary: %0d pixels, %0d frame ends, %0d brightness settings",
                 pixels_sent, frames_sent, settings_used);
        $display("summary: %0d SPI bytes checked, %0d mismatches",
                 bytes_checked, err_count);
        if (err_count == 0 && bytes_pending == 0) begin
            $display("led_pixel_spi_bit_encoder_tb: done, clean");
        end else begin
            $display("led_pixel_spi_bit_encoder_tb: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("timeout: %0d SPI bytes still expected", bytes_pending);
        $display("led_pixel_spi_bit_encoder_tb: done, errors");
        $finish;
    end

endmodule
